// ----- src/integer_pairing_unit_macros.svh -----
// shared assertion macros for the pairing unit
`ifndef INTEGER_PAIRING_UNIT_MACROS_SVH
`define INTEGER_PAIRING_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define IPU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ipu_pkg.sv -----
`default_nettype none

package ipu_pkg;

    // field widths of the request and response beats
    localparam int OP_W     = 3;
    localparam int COORD_W  = 16;
    localparam int PACKED_W = 33;
    localparam int WIDTH_W  = 17;
    localparam int PAIRED_W = 33;
    localparam int UNPAIR_W = 17;

    localparam int COORD_BITS_DEF = 16;
    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 17'd1;

    // radicand holds 8*z+1 for the cantor inverse
    localparam int RAD_SHIFT = 3;
    localparam int RAD_W     = PACKED_W + RAD_SHIFT;
    localparam int ROOT_W    = RAD_W / 2;

    // shared multiplier
    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;

    // square root pipeline: one result bit resolved per step
    localparam int SQRT_STEPS      = RAD_W / 2;
    localparam int STEPS_PER_STAGE = 3;
    localparam int SQRT_STAGES     = SQRT_STEPS / STEPS_PER_STAGE;

    // szudzik remainder z - s*s stays below 2*s+1
    localparam int REM_W = ROOT_W + 2;

    typedef enum logic [OP_W-1:0] {
        OP_LINEAR         = 3'd0,
        OP_CANTOR_PAIR    = 3'd1,
        OP_CANTOR_UNPAIR  = 3'd2,
        OP_SZUDZIK_PAIR   = 3'd3,
        OP_SZUDZIK_UNPAIR = 3'd4,
        OP_RS_PAIR        = 3'd5
    } t_op;

    // per-item sideband carried alongside the root
    typedef struct packed {
        t_op                 op;
        logic [PACKED_W-1:0] z;
        logic [MUL_W-1:0]    mul_a;
        logic [MUL_W-1:0]    mul_b;
        logic [MUL_W-1:0]    add_v;
        logic                halve;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
    } t_sqrt_state;

    // one step of the digit-by-digit square root
    function automatic t_sqrt_state isqrt_step(t_sqrt_state cur, int step);
        logic [RAD_W-1:0] v_bit;
        logic [RAD_W-1:0] v_trial;
        t_sqrt_state      v_nxt;
        v_bit   = RAD_W'(1) << (RAD_W - 2 - 2 * step);
        v_trial = cur.root + v_bit;
        if (cur.rem >= v_trial) begin
            v_nxt.rem  = cur.rem - v_trial;
            v_nxt.root = (cur.root >> 1) + v_bit;
        end else begin
            v_nxt.rem  = cur.rem;
            v_nxt.root = cur.root >> 1;
        end
        return v_nxt;
    endfunction

endpackage

`default_nettype wire

// ----- src/ipu_if.sv -----
`default_nettype none

interface ipu_req_if;
    import ipu_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [COORD_W-1:0]  x_coord;
    logic [COORD_W-1:0]  y_coord;
    logic [PACKED_W-1:0] packed_value;

    modport source (output valid, operation, x_coord, y_coord, packed_value, input ready);
    modport sink   (input valid, operation, x_coord, y_coord, packed_value, output ready);
endinterface

interface ipu_rsp_if;
    import ipu_pkg::*;

    logic                valid;
    logic                ready;
    logic [PAIRED_W-1:0] paired_out;
    logic [UNPAIR_W-1:0] first_out;
    logic [UNPAIR_W-1:0] second_out;
    logic                bad_operation;

    modport source (output valid, paired_out, first_out, second_out, bad_operation,
                    input ready);
    modport sink   (input valid, paired_out, first_out, second_out, bad_operation,
                    output ready);
endinterface

`default_nettype wire

// ----- src/ipu_isqrt_pipe.sv -----
`default_nettype none
`include "integer_pairing_unit_macros.svh"

module ipu_isqrt_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ipu_pkg::RAD_W-1:0]   i_rad,
    input  ipu_pkg::t_side              i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ipu_pkg::ROOT_W-1:0]  o_root,
    output ipu_pkg::t_side              o_side
);
    import ipu_pkg::*;

    localparam int Last = SQRT_STAGES - 1;

    logic [SQRT_STAGES-1:0] r_valid;
    logic [SQRT_STAGES-1:0] w_en;
    logic [SQRT_STAGES-1:0] w_vin;
    t_sqrt_state            r_st      [SQRT_STAGES];
    t_sqrt_state            n_st      [SQRT_STAGES];
    t_sqrt_state            w_st_in   [SQRT_STAGES];
    t_side                  r_side    [SQRT_STAGES];
    t_side                  w_side_in [SQRT_STAGES];
    logic [RAD_W:0]         w_root_dbl;

    // stage inputs
    always_comb begin
        w_st_in[0]   = t_sqrt_state'{rem: i_rad, root: '0};
        w_side_in[0] = i_side;
        w_vin[0]     = i_valid;
        for (int g = 1; g < SQRT_STAGES; g++) begin
            w_st_in[g]   = r_st[g-1];
            w_side_in[g] = r_side[g-1];
            w_vin[g]     = r_valid[g-1];
        end
    end

    // a few root steps per stage
    always_comb begin
        t_sqrt_state v_cur;
        for (int g = 0; g < SQRT_STAGES; g++) begin
            v_cur = w_st_in[g];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                v_cur = isqrt_step(v_cur, g * STEPS_PER_STAGE + j);
            end
            n_st[g] = v_cur;
        end
    end

    // a stage loads when empty or when the one after it moves
    always_comb begin
        w_en[Last] = !r_valid[Last] || i_ready;
        for (int g = Last - 1; g >= 0; g--) begin
            w_en[g] = !r_valid[g] || w_en[g+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int g = 0; g < SQRT_STAGES; g++) begin
                if (w_en[g]) begin
                    r_valid[g] <= w_vin[g];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < SQRT_STAGES; g++) begin
            if (w_en[g]) begin
                r_st[g]   <= n_st[g];
                r_side[g] <= w_side_in[g];
            end
        end
    end

    assign o_ready    = w_en[0];
    assign o_valid    = r_valid[Last];
    assign o_root     = r_st[Last].root[ROOT_W-1:0];
    assign o_side     = r_side[Last];
    assign w_root_dbl = {r_st[Last].root, 1'b0};

    `IPU_ASSERT_IMPL(a_root_exact, i_clk, i_rst_n, o_valid, (RAD_W+1)'(r_st[Last].rem) <= w_root_dbl, "remainder too large for a floor root")
    `IPU_ASSERT_IMPL(a_root_narrow, i_clk, i_rst_n, o_valid, r_st[Last].root[RAD_W-1:ROOT_W] == '0, "root wider than expected")
    `IPU_ASSERT_IMPL(a_full_only_stalled, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "pipe refused input with a bubble inside")

endmodule

`default_nettype wire

// ----- src/integer_pairing_unit.sv -----
// integer pairing unit
// request channel i_req: operation, x_coord, y_coord, packed_value; one beat per item
// response channel o_rsp: paired_out, first_out, second_out, bad_operation; one beat each
// operations: linear (y*image_width+x), cantor pair/unpair, szudzik pair/unpair,
// rosenberg-strong pair; codes 6 and 7 answer zeros with bad_operation set
// config: i_cfg_wr_en/i_cfg_wr_data write image_width; change it only while idle
// throughput: one beat per cycle in both directions, every operation
// latency: the response is valid 9 cycles after the accepting edge; the pipe is
// ten register stages (entry, six root stages of three steps each, operand
// select, multiply, result) and the 18-step square root sets its depth
// stall: every stage has its own valid bit and loads when empty or when the
// stage after it moves, so bubbles are squeezed out and up to ten items wait
// inside; i_req.ready drops only when all stages hold data and o_rsp.ready is low
// reset: synchronous active-low i_rst_n clears every valid bit and sets
// image_width to 1; no beat is in flight after reset
`default_nettype none
`include "integer_pairing_unit_macros.svh"

module integer_pairing_unit #(
    parameter int COORD_BITS = ipu_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ipu_pkg::WIDTH_W-1:0]   i_cfg_wr_data,
    ipu_req_if.sink                       i_req,
    ipu_rsp_if.source                     o_rsp
);
    import ipu_pkg::*;

    // coordinates are cut to COORD_BITS, capped at the port width
    localparam int CoordUseW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] CoordMask = COORD_W'((64'd1 << CoordUseW) - 64'd1);

    // config register
    logic [WIDTH_W-1:0]  r_image_width;

    // entry stage
    logic                r_e_valid;
    t_op                 r_e_op;
    logic [COORD_W-1:0]  r_e_x;
    logic [COORD_W-1:0]  r_e_y;
    logic [PACKED_W-1:0] r_e_z;

    // operand prep feeding the root pipe
    logic [MUL_W-1:0]    w_x;
    logic [MUL_W-1:0]    w_y;
    logic [MUL_W-1:0]    w_max;
    logic [MUL_W-1:0]    w_sum;
    logic                w_x_ge_y;
    t_side               w_side;
    logic [RAD_W-1:0]    w_rad;

    // root pipe outputs
    logic                w_sq_ready;
    logic                w_sq_valid;
    logic [ROOT_W-1:0]   w_sq_root;
    t_side               w_sq_side;

    // operand select stage
    logic                r_a_valid;
    t_side               r_a_side;
    t_side               n_a_side;
    logic [MUL_W-1:0]    w_q;

    // multiply stage
    logic                r_p_valid;
    logic [PROD_W-1:0]   r_p_prod;
    t_side               r_p_side;

    // result stage
    logic                r_o_valid;
    logic [PAIRED_W-1:0] r_o_paired;
    logic [UNPAIR_W-1:0] r_o_first;
    logic [UNPAIR_W-1:0] r_o_second;
    logic                r_o_bad;
    logic [PAIRED_W-1:0] n_o_paired;
    logic [UNPAIR_W-1:0] n_o_first;
    logic [UNPAIR_W-1:0] n_o_second;
    logic                n_o_bad;
    logic [PROD_W-1:0]   w_half;
    logic [UNPAIR_W-1:0] w_tri;
    logic [REM_W-1:0]    w_rem;
    logic [REM_W-1:0]    w_root_r;
    logic [REM_W-1:0]    w_rem_hi;

    // stage enables: load when empty or when the next stage moves
    logic                w_en_e;
    logic                w_en_a;
    logic                w_en_p;
    logic                w_en_o;

    assign w_en_o = !r_o_valid || o_rsp.ready;
    assign w_en_p = !r_p_valid || w_en_o;
    assign w_en_a = !r_a_valid || w_en_p;
    assign w_en_e = !r_e_valid || w_sq_ready;

    assign i_req.ready = w_en_e;

    // image width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            r_image_width <= i_cfg_wr_data;
        end
    end

    // entry stage: capture the request beat, coordinates masked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en_e) begin
            r_e_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_e) begin
            r_e_op <= t_op'(i_req.operation);
            r_e_x  <= i_req.x_coord & CoordMask;
            r_e_y  <= i_req.y_coord & CoordMask;
            r_e_z  <= i_req.packed_value;
        end
    end

    // pairing operations reduce to a*b (optionally halved) plus an addend
    assign w_x      = MUL_W'(r_e_x);
    assign w_y      = MUL_W'(r_e_y);
    assign w_x_ge_y = (r_e_x >= r_e_y);
    assign w_max    = w_x_ge_y ? w_x : w_y;
    assign w_sum    = w_x + w_y;

    always_comb begin
        w_side       = '0;
        w_side.op    = r_e_op;
        w_side.z     = r_e_z;
        case (r_e_op)
            OP_LINEAR: begin
                w_side.mul_a = w_y;
                w_side.mul_b = MUL_W'(r_image_width);
                w_side.add_v = w_x;
            end
            OP_CANTOR_PAIR: begin
                // s*(s+1)/2 + y
                w_side.mul_a = w_sum;
                w_side.mul_b = w_sum + MUL_W'(1);
                w_side.add_v = w_y;
                w_side.halve = 1'b1;
            end
            OP_CANTOR_UNPAIR: begin
                // operands come from the root later
                w_side.halve = 1'b1;
            end
            OP_SZUDZIK_PAIR: begin
                // x>=y: x*x+x+y, else y*y+x
                w_side.mul_a = w_max;
                w_side.mul_b = w_max;
                w_side.add_v = w_x_ge_y ? w_sum : w_x;
            end
            OP_RS_PAIR: begin
                // m*m + m + x - y, never negative
                w_side.mul_a = w_max;
                w_side.mul_b = w_max;
                w_side.add_v = w_max + w_x - w_y;
            end
            default: begin
            end
        endcase
    end

    // cantor inverse takes the root of 8z+1, szudzik inverse the root of z
    assign w_rad = (r_e_op == OP_CANTOR_UNPAIR) ? {r_e_z, RAD_SHIFT'(1)} : RAD_W'(r_e_z);

    ipu_isqrt_pipe u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_valid),
        .o_ready (w_sq_ready),
        .i_rad   (w_rad),
        .i_side  (w_side),
        .o_valid (w_sq_valid),
        .i_ready (w_en_a),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // operand select: the inverses square or triangle the root
    assign w_q = (MUL_W'(w_sq_root) - MUL_W'(1)) >> 1;

    always_comb begin
        n_a_side = w_sq_side;
        case (w_sq_side.op)
            OP_CANTOR_UNPAIR: begin
                // shell index q = (root - 1) / 2, triangle q*(q+1)/2
                n_a_side.mul_a = w_q;
                n_a_side.mul_b = w_q + MUL_W'(1);
            end
            OP_SZUDZIK_UNPAIR: begin
                n_a_side.mul_a = MUL_W'(w_sq_root);
                n_a_side.mul_b = MUL_W'(w_sq_root);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en_a) begin
            r_a_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_side <= n_a_side;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en_p) begin
            r_p_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_p) begin
            r_p_prod <= r_a_side.mul_a * r_a_side.mul_b;
            r_p_side <= r_a_side;
        end
    end

    // result stage
    assign w_half   = r_p_side.halve ? (r_p_prod >> 1) : r_p_prod;
    assign w_tri    = w_half[UNPAIR_W-1:0];
    assign w_rem    = r_p_side.z[REM_W-1:0] - r_p_prod[REM_W-1:0];
    assign w_root_r = REM_W'(r_p_side.mul_a);
    assign w_rem_hi = w_rem - w_root_r;

    always_comb begin
        n_o_paired = '0;
        n_o_first  = '0;
        n_o_second = '0;
        n_o_bad    = 1'b0;
        case (r_p_side.op)
            OP_LINEAR, OP_CANTOR_PAIR, OP_SZUDZIK_PAIR, OP_RS_PAIR: begin
                n_o_paired = w_half[PAIRED_W-1:0] + PAIRED_W'(r_p_side.add_v);
            end
            OP_CANTOR_UNPAIR: begin
                // y = z - T, x = T + q - z
                n_o_second = r_p_side.z[UNPAIR_W-1:0] - w_tri;
                n_o_first  = w_tri + r_p_side.mul_a[UNPAIR_W-1:0]
                             - r_p_side.z[UNPAIR_W-1:0];
            end
            OP_SZUDZIK_UNPAIR: begin
                if (w_rem < w_root_r) begin
                    n_o_first  = w_rem[UNPAIR_W-1:0];
                    n_o_second = r_p_side.mul_a[UNPAIR_W-1:0];
                end else begin
                    n_o_first  = r_p_side.mul_a[UNPAIR_W-1:0];
                    n_o_second = w_rem_hi[UNPAIR_W-1:0];
                end
            end
            default: begin
                n_o_bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en_o) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_o) begin
            r_o_paired <= n_o_paired;
            r_o_first  <= n_o_first;
            r_o_second <= n_o_second;
            r_o_bad    <= n_o_bad;
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.paired_out    = r_o_paired;
    assign o_rsp.first_out     = r_o_first;
    assign o_rsp.second_out    = r_o_second;
    assign o_rsp.bad_operation = r_o_bad;

    `IPU_ASSERT_IMPL(a_bad_op_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.bad_operation, o_rsp.paired_out == '0 && o_rsp.first_out == '0 && o_rsp.second_out == '0, "bad operation beat carries data")
    `IPU_ASSERT_IMPL(a_busy_only_stalled, i_clk, i_rst_n, !i_req.ready, r_o_valid && !o_rsp.ready, "request refused without an output stall")
    `IPU_ASSERT_NEXT(a_no_repeat, i_clk, i_rst_n, o_rsp.valid && o_rsp.ready && !r_p_valid, !r_o_valid, "response beat repeated")

endmodule

`default_nettype wire

// ----- verif/tb_integer_pairing_unit.sv -----
`default_nettype none

module tb_integer_pairing_unit;
    import ipu_pkg::*;

    // codes the block answers with bad_operation
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    localparam logic [COORD_W-1:0]  COORD_MAX  = {COORD_W{1'b1}};
    localparam logic [PACKED_W-1:0] PACKED_MAX = {PACKED_W{1'b1}};
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = {WIDTH_W{1'b1}};

    localparam int N_DIRECTED    = 22;
    localparam int N_PHASES      = 6;
    localparam int PHASE_ITEMS   = 275;
    // long receiver hold-off, well past the ten stages the block can buffer
    localparam int HOLD_CYCLES   = 80;
    // drain margin after the last response, the pipe is ten stages deep
    localparam int TAIL_CYCLES   = 20;
    // cycles with no beat on either channel before the run is declared hung
    localparam int IDLE_LIMIT    = 1000;

    typedef struct packed {
        logic [PAIRED_W-1:0] paired;
        logic [UNPAIR_W-1:0] first;
        logic [UNPAIR_W-1:0] second;
        logic                bad;
    } pair_result_t;

    // one request beat, with a hand-typed answer where typed is set
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [PACKED_W-1:0] z;
        bit                  typed;
        pair_result_t        res;
    } pair_request_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_PERIODIC,
        SINK_HEAVY
    } sink_mode_t;

    logic i_clk;
    logic i_rst_n;
    logic                i_cfg_wr_en;
    logic [WIDTH_W-1:0]  i_cfg_wr_data;

    ipu_req_if req_bus ();
    ipu_rsp_if rsp_bus ();

    integer_pairing_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_bus),
        .o_rsp         (rsp_bus)
    );

    // expected response beats, oldest first
    pair_result_t       pending_results[$];
    // our copy of image_width, follows every register write
    logic [WIDTH_W-1:0] width_shadow = IMAGE_WIDTH_RST;
    int                 err_count    = 0;
    int                 idle_cycles  = 0;
    // main bumps hold_requests, the receiver answers with one long hold-off
    int                 hold_requests = 0;

    t_op good_ops[6] = '{OP_LINEAR, OP_CANTOR_PAIR, OP_CANTOR_UNPAIR,
                         OP_SZUDZIK_PAIR, OP_SZUDZIK_UNPAIR, OP_RS_PAIR};

    // directed beats: extremes of every operation, unused fields driven high,
    // bad codes, perfect square and triangle boundaries; width is still 1
    pair_request_t directed_rows [N_DIRECTED] = '{
        '{OP_LINEAR,         16'd0,     16'd0,     33'd0,      1'b1, '{33'd0, 17'd0, 17'd0, 1'b0}},
        '{OP_LINEAR,         COORD_MAX, COORD_MAX, 33'd0,      1'b1, '{33'd131070, 17'd0, 17'd0, 1'b0}},
        '{OP_CANTOR_PAIR,    16'd0,     16'd0,     PACKED_MAX, 1'b1, '{33'd0, 17'd0, 17'd0, 1'b0}},
        '{OP_CANTOR_PAIR,    COORD_MAX, COORD_MAX, PACKED_MAX, 1'b0, '0},
        '{OP_CANTOR_PAIR,    COORD_MAX, 16'd0,     33'd0,      1'b0, '0},
        '{OP_CANTOR_PAIR,    16'd0,     COORD_MAX, 33'd0,      1'b0, '0},
        '{OP_CANTOR_UNPAIR,  COORD_MAX, COORD_MAX, 33'd0,      1'b1, '{33'd0, 17'd0, 17'd0, 1'b0}},
        '{OP_CANTOR_UNPAIR,  COORD_MAX, COORD_MAX, PACKED_MAX, 1'b0, '0},
        '{OP_CANTOR_UNPAIR,  16'd0,     16'd0,     33'd5,      1'b0, '0},
        '{OP_SZUDZIK_PAIR,   16'd0,     16'd0,     PACKED_MAX, 1'b1, '{33'd0, 17'd0, 17'd0, 1'b0}},
        '{OP_SZUDZIK_PAIR,   COORD_MAX, COORD_MAX, 33'd0,      1'b0, '0},
        '{OP_SZUDZIK_PAIR,   16'd0,     COORD_MAX, 33'd0,      1'b0, '0},
        '{OP_SZUDZIK_PAIR,   COORD_MAX, 16'd0,     33'd0,      1'b0, '0},
        '{OP_SZUDZIK_UNPAIR, COORD_MAX, COORD_MAX, 33'd0,      1'b1, '{33'd0, 17'd0, 17'd0, 1'b0}},
        '{OP_SZUDZIK_UNPAIR, 16'd0,     16'd0,     PACKED_MAX, 1'b0, '0},
        '{OP_SZUDZIK_UNPAIR, 16'd0,     16'd0,     33'd16,     1'b0, '0},
        '{OP_RS_PAIR,        16'd0,     16'd0,     PACKED_MAX, 1'b1, '{33'd0, 17'd0, 17'd0, 1'b0}},
        '{OP_RS_PAIR,        COORD_MAX, COORD_MAX, 33'd0,      1'b0, '0},
        '{OP_RS_PAIR,        16'd0,     COORD_MAX, 33'd0,      1'b0, '0},
        '{OP_RS_PAIR,        COORD_MAX, 16'd0,     33'd0,      1'b0, '0},
        '{OP_UNUSED_A,       COORD_MAX, COORD_MAX, PACKED_MAX, 1'b1, '{33'd0, 17'd0, 17'd0, 1'b1}},
        '{OP_UNUSED_B,       COORD_MAX, COORD_MAX, PACKED_MAX, 1'b1, '{33'd0, 17'd0, 17'd0, 1'b1}}
    };

    // widths for the random phases: plain, zero (linear gives x), all ones,
    // the top of the legal range, a typical row, and one drawn at run time
    logic [WIDTH_W-1:0] phase_widths [N_PHASES] = '{
        17'd1, 17'd0, WIDTH_MAX, 17'd65536, 17'd640, 17'd1
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor square root, one result bit at a time from the top
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // expected response for one request at the current image width
    function automatic pair_result_t pair_predict(logic [OP_W-1:0] op,
                                                  logic [COORD_W-1:0] xc,
                                                  logic [COORD_W-1:0] yc,
                                                  logic [PACKED_W-1:0] zc,
                                                  logic [WIDTH_W-1:0] width);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] paired;
        logic [63:0] first;
        logic [63:0] second;
        pair_result_t res;
        x      = 64'(xc);
        y      = 64'(yc);
        z      = 64'(zc);
        paired = 64'd0;
        first  = 64'd0;
        second = 64'd0;
        res.bad = 1'b0;
        case (op)
            OP_LINEAR: begin
                paired = y * 64'(width) + x;
            end
            OP_CANTOR_PAIR: begin
                s      = x + y;
                paired = s * (s + 64'd1) / 64'd2 + y;
            end
            OP_CANTOR_UNPAIR: begin
                // shell index from the floor root of 8z+1
                s      = (floor_root(z * 64'd8 + 64'd1) - 64'd1) / 64'd2;
                second = z - s * (s + 64'd1) / 64'd2;
                first  = s * (s + 64'd3) / 64'd2 - z;
            end
            OP_SZUDZIK_PAIR: begin
                paired = (x >= y) ? x * x + x + y : y * y + x;
            end
            OP_SZUDZIK_UNPAIR: begin
                s = floor_root(z);
                r = z - s * s;
                if (r < s) begin
                    first  = r;
                    second = s;
                end else begin
                    first  = s;
                    second = r - s;
                end
            end
            OP_RS_PAIR: begin
                m      = (x > y) ? x : y;
                paired = m * m + m + x - y;
            end
            default: begin
                res.bad = 1'b1;
            end
        endcase
        res.paired = paired[PAIRED_W-1:0];
        res.first  = first[UNPAIR_W-1:0];
        res.second = second[UNPAIR_W-1:0];
        return res;
    endfunction

    // coordinates lean on the corners as well as the full range
    function automatic logic [COORD_W-1:0] random_coord();
        logic [COORD_W-1:0] c;
        case ($urandom_range(0, 3))
            0:       c = COORD_W'($urandom_range(0, 15));
            1:       c = COORD_MAX - COORD_W'($urandom_range(0, 15));
            default: c = COORD_W'($urandom);
        endcase
        return c;
    endfunction

    // packed values near squares and triangle numbers hit the shell edges
    function automatic logic [PACKED_W-1:0] random_packed();
        logic [63:0] k;
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: begin
                k = 64'($urandom_range(0, 92681));
                v = k * k + 64'($urandom_range(0, 2)) - 64'd1;
            end
            1: begin
                k = 64'($urandom_range(0, 131070));
                v = k * (k + 64'd1) / 64'd2 + 64'($urandom_range(0, 2)) - 64'd1;
            end
            2:       v = 64'($urandom_range(0, 255));
            3:       v = 64'(PACKED_MAX) - 64'($urandom_range(0, 255));
            default: v = {$urandom, $urandom};
        endcase
        return v[PACKED_W-1:0];
    endfunction

    function automatic pair_request_t random_request();
        pair_request_t row;
        row = '0;
        if ($urandom_range(0, 7) == 0) begin
            row.op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
        end else begin
            row.op = good_ops[$urandom_range(0, 5)];
        end
        row.x = random_coord();
        row.y = random_coord();
        row.z = random_packed();
        return row;
    endfunction

    // offer one request beat, hold it until accepted, then log its answer
    task automatic offer(pair_request_t row);
        req_bus.valid        <= 1'b1;
        req_bus.operation    <= row.op;
        req_bus.x_coord      <= row.x;
        req_bus.y_coord      <= row.y;
        req_bus.packed_value <= row.z;
        @(posedge i_clk);
        while (!req_bus.ready) begin
            @(posedge i_clk);
        end
        if (row.typed) begin
            pending_results.push_back(row.res);
        end else begin
            pending_results.push_back(pair_predict(row.op, row.x, row.y, row.z, width_shadow));
        end
    endtask

    // register write, only once the pipe has drained
    task automatic write_width(logic [WIDTH_W-1:0] w);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        width_shadow = w;
    endtask

    // random requests in bursts with gaps; some phases run back to back
    task automatic run_random(int count);
        int  burst_left;
        bit  steady;
        steady     = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < count; i++) begin
            offer(random_request());
            burst_left--;
            if (!steady && burst_left == 0 && i != count - 1) begin
                req_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 40);
            end
        end
        req_bus.valid <= 1'b0;
    endtask

    // main sequence: reset, directed beats, then one random phase per width
    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_wr_en          <= 1'b0;
        i_cfg_wr_data        <= '0;
        req_bus.valid        <= 1'b0;
        req_bus.operation    <= '0;
        req_bus.x_coord      <= '0;
        req_bus.y_coord      <= '0;
        req_bus.packed_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            offer(directed_rows[k]);
        end
        req_bus.valid <= 1'b0;

        phase_widths[N_PHASES-1] = WIDTH_W'($urandom_range(1, 65536));
        for (int k = 0; k < N_PHASES; k++) begin
            write_width(phase_widths[k]);
            // the receiver backs off for a while so the pipe fills
            if (k == 0 || k == 3) begin
                hold_requests <= hold_requests + 1;
            end
            run_random(PHASE_ITEMS);
        end

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // receiver: segments of open, light, periodic and heavy stalls, plus the
    // long hold-offs that main asks for
    initial begin
        int         hold_served;
        int         seg;
        int         tick;
        sink_mode_t mode;
        hold_served = 0;
        tick        = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            if (hold_served != hold_requests) begin
                hold_served++;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = sink_mode_t'($urandom_range(0, 3));
                seg  = $urandom_range(5, 60);
                repeat (seg) begin
                    case (mode)
                        SINK_OPEN:     rsp_bus.ready <= 1'b1;
                        SINK_LIGHT:    rsp_bus.ready <= ($urandom_range(0, 2) != 0);
                        SINK_PERIODIC: rsp_bus.ready <= (tick % 4 != 3);
                        default:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                    tick++;
                end
            end
        end
    end

    // compare each response beat with the oldest expectation
    always @(posedge i_clk) begin : rsp_check
        pair_result_t want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                $error("response beat with nothing expected");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_bus.paired_out !== want.paired) begin
                    $error("paired_out: expected %0d, got %0d", want.paired, rsp_bus.paired_out);
                    err_count++;
                end
                if (rsp_bus.first_out !== want.first) begin
                    $error("first_out: expected %0d, got %0d", want.first, rsp_bus.first_out);
                    err_count++;
                end
                if (rsp_bus.second_out !== want.second) begin
                    $error("second_out: expected %0d, got %0d", want.second, rsp_bus.second_out);
                    err_count++;
                end
                if (rsp_bus.bad_operation !== want.bad) begin
                    $error("bad_operation: expected %0d, got %0d",
                           want.bad, rsp_bus.bad_operation);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

`default_nettype wire
